// ----- rtl/gkm_pkg.sv -----
`timescale 1ns / 1ps
// gkm_pkg: shared types, codes and constants of the gamepad key event mapper
// no dependencies

package gkm_pkg;

  localparam int MOVE_FRACTION_BITS = 16;
  localparam int SHIFT_UP = (MOVE_FRACTION_BITS >= 16) ? MOVE_FRACTION_BITS - 16 : 0;
  localparam int SHIFT_DN = (MOVE_FRACTION_BITS < 16) ? 16 - MOVE_FRACTION_BITS : 0;

  localparam int NUM_KEYS  = 26;
  localparam int NUM_SLOTS = 30;
  localparam int CFG_W     = 16;

  // commands
  localparam logic [1:0] CMD_SNAP    = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // event kinds
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_MOUSE   = 3'd1;
  localparam logic [2:0] KIND_CAM     = 3'd2;
  localparam logic [2:0] KIND_MOVE    = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  // register indexes
  localparam logic [2:0] REG_SWAP     = 3'd0;
  localparam logic [2:0] REG_RADIAL   = 3'd1;
  localparam logic [2:0] REG_LT_THR   = 3'd2;
  localparam logic [2:0] REG_RT_THR   = 3'd3;
  localparam logic [2:0] REG_MOVE_THR = 3'd4;
  localparam logic [2:0] REG_DEADZONE = 3'd5;
  localparam logic [2:0] REG_SPEED    = 3'd6;
  localparam logic [2:0] REG_CURVE    = 3'd7;

  typedef struct packed {
    logic        swap_sticks;
    logic        simple_radial;
    logic [7:0]  left_trigger_threshold;
    logic [7:0]  right_trigger_threshold;
    logic [6:0]  movement_threshold;
    logic [6:0]  cursor_deadzone;
    logic [15:0] cursor_speed;
    logic [15:0] cursor_curve;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]          cmd;
    logic [NUM_KEYS-1:0] keys;
    logic [1:0]          mouse;
    logic                allow;
    logic signed [7:0]   px;
    logic signed [7:0]   py;
  } entry_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] keys;
    logic [1:0]          mouse;
    logic                cam;
  } status_t;

endpackage

// ----- rtl/gkm_if.sv -----
`timescale 1ns / 1ps
// gkm_in_if / gkm_out_if: valid-ready channels of the mapper
// no dependencies

interface gkm_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [7:0] left_x;
  logic signed [7:0] left_y;
  logic signed [7:0] right_x;
  logic signed [7:0] right_y;
  logic [7:0]        left_trigger;
  logic [7:0]        right_trigger;
  logic [19:0]       buttons;
  logic              allow_mouse;

  modport source (output valid, cmd, left_x, left_y, right_x, right_y, left_trigger,
                  right_trigger, buttons, allow_mouse, input ready);
  modport sink   (input valid, cmd, left_x, left_y, right_x, right_y, left_trigger,
                  right_trigger, buttons, allow_mouse, output ready);
endinterface

interface gkm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_kind;
  logic [4:0]         code;
  logic               level;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic               last;

  modport source (output valid, event_kind, code, level, move_x, move_y, last,
                  input ready);
  modport sink   (input valid, event_kind, code, level, move_x, move_y, last,
                  output ready);
endinterface

// ----- rtl/gkm_front.sv -----
`timescale 1ns / 1ps
// gkm_front: accepts items and turns them into target key and mouse levels
// depends on gkm_pkg, gkm_if

module gkm_front import gkm_pkg::*; (
  gkm_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output entry_t   ent
);

  logic signed [9:0]  mx, my, thr;
  logic [9:0]         ax, ay;
  logic [10:0]        ax2, ay2, ax3, ay3;
  logic               left, right, upk, down, diag;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    mx  = cfg.swap_sticks ? 10'(in_ch.right_x) : 10'(in_ch.left_x);
    my  = cfg.swap_sticks ? 10'(in_ch.right_y) : 10'(in_ch.left_y);
    thr = $signed({3'b000, cfg.movement_threshold});
    left  = mx < -thr;
    right = mx > thr;
    upk   = my < -thr;
    down  = my > thr;
    ax  = (mx < 0) ? 10'(-mx) : 10'(mx);
    ay  = (my < 0) ? 10'(-my) : 10'(my);
    ax2 = {ax, 1'b0};
    ay2 = {ay, 1'b0};
    ax3 = 11'(ax) + {ax, 1'b0};
    ay3 = 11'(ay) + {ay, 1'b0};
    diag = (left || right) && (upk || down) && !cfg.simple_radial;

    ent.cmd        = in_ch.cmd;
    ent.keys[0]    = in_ch.left_trigger > cfg.left_trigger_threshold;
    ent.keys[1]    = in_ch.right_trigger > cfg.right_trigger_threshold;
    ent.keys[19:2] = in_ch.buttons[17:0];
    ent.keys[20]   = upk;
    ent.keys[21]   = left;
    ent.keys[22]   = down;
    ent.keys[23]   = right;
    ent.keys[24]   = diag && (ax2 > ay3);
    ent.keys[25]   = diag && (ay2 > ax3);
    ent.mouse      = in_ch.allow_mouse ? in_ch.buttons[19:18] : 2'b00;
    ent.allow      = in_ch.allow_mouse;
    ent.px         = cfg.swap_sticks ? in_ch.left_x : in_ch.right_x;
    ent.py         = cfg.swap_sticks ? in_ch.left_y : in_ch.right_y;
  end

endmodule

// ----- rtl/gkm_queue.sv -----
`timescale 1ns / 1ps
// gkm_queue: two-entry queue between front and back
// depends on gkm_pkg

module gkm_queue import gkm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head,
  output logic [1:0] count
);

  entry_t slots [2];
  logic   wr_ptr, rd_ptr;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/gkm_back.sv -----
`timescale 1ns / 1ps
// gkm_back: pointer arithmetic, level compare and event sequencing
// depends on gkm_pkg, gkm_if

module gkm_back import gkm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  entry_t    q_head,
  output logic      q_pop,
  gkm_out_if.source out_ch,
  output status_t   status
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PREP  = 12'b000000000010,
    S_SQRT  = 12'b000000000100,
    S_DSET  = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_SMUL  = 12'b000000100000,
    S_SDSET = 12'b000001000000,
    S_SDIV  = 12'b000010000000,
    S_TMUL  = 12'b000100000000,
    S_TFIN  = 12'b001000000000,
    S_BUILD = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  localparam logic [48:0] SAT_LIM = 49'(64'h7FFFFFFF >> SHIFT_UP);
  localparam logic [31:0] SAT_MAG = 32'h7FFFFFFF;
  // ceil(2^26 / 20), exact for dividends below 2^22
  localparam logic [21:0] RECIP20 = 22'd3355444;

  state_t        state;
  entry_t        ent;
  logic [47:0]   rad;
  logic [26:0]   srem;
  logic [23:0]   root;
  logic [5:0]    cnt;
  logic          axis;
  logic [55:0]   dvd, quo, prod;
  logic [31:0]   dvs, sc, s_low, out_x, out_y;
  logic [32:0]   drem;
  logic [63:0]   sq;
  logic          s_big, mode, cam_tgt;
  logic [NUM_SLOTS-1:0] pend;
  logic [NUM_KEYS-1:0]  keys;
  logic [1:0]    mouse;
  logic          cam;

  logic          o_valid, o_level, o_last;
  logic [2:0]    o_kind;
  logic [4:0]    o_code;
  logic [31:0]   o_mx, o_my;

  // combinational helpers
  logic [15:0]   m2, dz2;
  logic [26:0]   rem_sh, trial;
  logic [32:0]   dsh;
  logic signed [7:0] c;
  logic [7:0]    ac;
  logic [23:0]   diff;
  logic [6:0]    divr;
  logic [48:0]   t, t_dn, t_up;
  logic [31:0]   mag, axis_out;
  logic          active;
  logic [NUM_SLOTS-1:0] pend_new, onehot;
  logic [4:0]    sel;
  logic          emit_go;
  logic [20:0]   d20_p, d20_sub;
  logic [42:0]   d20_prod;
  logic [15:0]   d20_q;
  logic [2:0]    e_kind;
  logic [4:0]    e_code;
  logic          e_level;
  logic [31:0]   e_mx, e_my;

  assign m2  = 16'(ent.px * ent.px) + 16'(ent.py * ent.py);
  assign dz2 = 16'(cfg.cursor_deadzone * cfg.cursor_deadzone);
  assign rem_sh = {srem[24:0], rad[47:46]};
  assign trial  = {1'b0, root, 2'b01};
  assign dsh    = {drem[31:0], dvd[55]};
  assign c      = axis ? ent.py : ent.px;
  assign ac     = (c < 0) ? 8'(-c) : 8'(c);
  assign diff   = root - {1'b0, cfg.cursor_deadzone, 16'b0};
  assign divr   = (cfg.cursor_deadzone < 7'd127) ? 7'd127 - cfg.cursor_deadzone : 7'd1;
  assign active = ent.allow && ((out_x != 32'd0) || (out_y != 32'd0));

  // radix 2^16 digit of the divide by 20, remainder carried in drem
  assign d20_p    = {drem[4:0], dvd[47:32]};
  assign d20_prod = 43'(d20_p) * 43'(RECIP20);
  assign d20_q    = d20_prod[41:26];
  assign d20_sub  = d20_p - 21'(d20_q) * 21'd20;

  // curve result of one axis
  always_comb begin
    t    = {1'b0, sq[63:16]} + {17'b0, s_low};
    t_dn = t >> SHIFT_DN;
    t_up = t_dn << SHIFT_UP;
    mag  = (s_big || t_dn > SAT_LIM) ? SAT_MAG : t_up[31:0];
    axis_out = (c < 0) ? 32'(0) - mag : mag;
  end

  // pending event mask per command
  always_comb begin
    pend_new = '0;
    case (ent.cmd)
      CMD_SNAP: begin
        pend_new[19:0]  = ent.keys[19:0] ^ keys[19:0];
        pend_new[21:20] = ent.mouse ^ mouse;
        pend_new[27:22] = ent.keys[25:20] ^ keys[25:20];
        pend_new[28]    = active ^ cam;
        pend_new[29]    = active;
      end
      CMD_CANCEL: begin
        pend_new[1:0] = mouse;
        pend_new[2]   = cam;
      end
      CMD_RELEASE: begin
        pend_new[1:0]  = mouse;
        pend_new[2]    = cam;
        pend_new[28:3] = keys;
        pend_new[29]   = 1'b1;
      end
      default: pend_new = '0;
    endcase
  end

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel = 5'(i);
    end
    onehot = NUM_SLOTS'(1) << sel;
  end

  // fields of the event in the selected slot
  always_comb begin
    e_kind  = KIND_KEY;
    e_code  = '0;
    e_level = 1'b0;
    e_mx    = '0;
    e_my    = '0;
    if (!mode) begin
      if (sel < 5'd20) begin
        e_kind  = KIND_KEY;
        e_code  = sel;
        e_level = ent.keys[sel];
      end else if (sel < 5'd22) begin
        e_kind  = KIND_MOUSE;
        e_code  = sel - 5'd20;
        e_level = ent.mouse[sel[0]];
      end else if (sel < 5'd28) begin
        e_kind  = KIND_KEY;
        e_code  = sel - 5'd2;
        e_level = ent.keys[sel - 5'd2];
      end else if (sel == 5'd28) begin
        e_kind  = KIND_CAM;
        e_level = cam_tgt;
      end else begin
        e_kind = KIND_MOVE;
        e_mx   = out_x;
        e_my   = out_y;
      end
    end else begin
      if (sel < 5'd2) begin
        e_kind = KIND_MOUSE;
        e_code = sel;
      end else if (sel == 5'd2) begin
        e_kind = KIND_CAM;
      end else if (sel < 5'd29) begin
        e_kind = KIND_KEY;
        e_code = sel - 5'd3;
      end else begin
        e_kind = KIND_RELEASE;
      end
    end
  end

  assign emit_go = (state == S_EMIT) && (!o_valid || out_ch.ready);
  assign q_pop   = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      keys    <= '0;
      mouse   <= '0;
      cam     <= 1'b0;
      o_valid <= 1'b0;
      pend    <= '0;
    end else begin
      if (emit_go) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ent   <= q_head;
            out_x <= '0;
            out_y <= '0;
            state <= (q_head.cmd == CMD_SNAP) ? S_PREP : S_BUILD;
          end
        end
        S_PREP: begin
          sc <= cfg.cursor_speed * cfg.cursor_curve;
          if (m2 != 16'd0 && m2 >= dz2) begin
            rad   <= {m2, 32'b0};
            srem  <= '0;
            root  <= '0;
            cnt   <= 6'd23;
            state <= S_SQRT;
          end else begin
            state <= S_BUILD;
          end
        end
        S_SQRT: begin
          rad <= {rad[45:0], 2'b00};
          if (rem_sh >= trial) begin
            srem <= rem_sh - trial;
            root <= {root[22:0], 1'b1};
          end else begin
            srem <= rem_sh;
            root <= {root[22:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            axis  <= 1'b0;
            state <= S_DSET;
          end
        end
        S_DSET: begin
          dvd   <= {8'b0, 32'(ac * diff), 16'b0};
          dvs   <= 32'(root * divr);
          drem  <= '0;
          cnt   <= 6'd55;
          state <= S_DIV;
        end
        S_DIV: begin
          dvd <= {dvd[54:0], 1'b0};
          if (dsh >= {1'b0, dvs}) begin
            drem <= dsh - {1'b0, dvs};
            quo  <= {quo[54:0], 1'b1};
          end else begin
            drem <= dsh;
            quo  <= {quo[54:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_SMUL;
        end
        S_SMUL: begin
          prod  <= 56'(quo[23:0] * sc);
          state <= S_SDSET;
        end
        S_SDSET: begin
          dvd   <= {16'b0, prod[55:16]};
          quo   <= '0;
          drem  <= '0;
          cnt   <= 6'd2;
          state <= S_SDIV;
        end
        // three 16-bit digits of the divide by 20
        S_SDIV: begin
          dvd  <= {dvd[39:0], 16'b0};
          quo  <= {quo[39:0], d20_q};
          drem <= {28'b0, d20_sub[4:0]};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) state <= S_TMUL;
        end
        S_TMUL: begin
          s_big <= |quo[55:32];
          s_low <= quo[31:0];
          sq    <= quo[31:0] * quo[31:0];
          state <= S_TFIN;
        end
        S_TFIN: begin
          if (axis) begin
            out_y <= axis_out;
            state <= S_BUILD;
          end else begin
            out_x <= axis_out;
            axis  <= 1'b1;
            state <= S_DSET;
          end
        end
        S_BUILD: begin
          pend    <= pend_new;
          mode    <= ent.cmd != CMD_SNAP;
          cam_tgt <= active;
          state   <= (pend_new == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            o_kind  <= e_kind;
            o_code  <= e_code;
            o_level <= e_level;
            o_mx    <= e_mx;
            o_my    <= e_my;
            o_last  <= (pend & ~onehot) == '0;
            pend    <= pend & ~onehot;
            if (!mode) begin
              if (sel < 5'd20) begin
                keys[sel] <= ent.keys[sel];
              end else if (sel < 5'd22) begin
                mouse[sel[0]] <= ent.mouse[sel[0]];
              end else if (sel < 5'd28) begin
                keys[sel - 5'd2] <= ent.keys[sel - 5'd2];
              end else if (sel == 5'd28) begin
                cam <= cam_tgt;
              end
            end else begin
              if (sel < 5'd2) begin
                mouse[sel[0]] <= 1'b0;
              end else if (sel == 5'd2) begin
                cam <= 1'b0;
              end else if (sel < 5'd29) begin
                keys[sel - 5'd3] <= 1'b0;
              end else begin
                keys  <= '0;
                mouse <= '0;
                cam   <= 1'b0;
              end
            end
            if ((pend & ~onehot) == '0) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.event_kind = o_kind;
  assign out_ch.code       = o_code;
  assign out_ch.level      = o_level;
  assign out_ch.move_x     = o_mx;
  assign out_ch.move_y     = o_my;
  assign out_ch.last       = o_last;

  assign status.keys  = keys;
  assign status.mouse = mouse;
  assign status.cam   = cam;

endmodule

// ----- rtl/gamepad_to_key_event_mapper_unit.sv -----
`timescale 1ns / 1ps
// gamepad_to_key_event_mapper_unit: top level, config registers and assertions
// depends on gkm_pkg, gkm_if, gkm_front, gkm_queue, gkm_back
//
//  channel   dir  handshake      payload
//  gp_in     in   valid/ready    cmd, sticks, triggers, buttons, allow_mouse
//  ev_out    out  valid/ready    event_kind, code, level, move_x, move_y, last
//  cfg       in   cfg_we         cfg_index (3), cfg_data (16)
//
// sequence: a command other than a snapshot goes straight to its event mask; a
// snapshot with the pointer outside the deadzone first runs the bit-serial square
// root and two passes of the shared divider, one per axis, before its events are
// sent; otherwise a snapshot skips that pointer arithmetic
// reset: synchronous, clears kept levels, queue and output register
// stalls: the two-entry queue lets the front take items while the back
// waits on ev_out.ready; the output register holds an event until taken

module gamepad_to_key_event_mapper_unit import gkm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  gkm_in_if.sink             gp_in,
  gkm_out_if.source          ev_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  cfg_t    cfg;
  entry_t  f_ent, q_head;
  logic    push, pop, q_full, q_valid;
  logic [1:0] q_count;
  status_t status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_sticks             <= 1'b0;
      cfg.simple_radial           <= 1'b0;
      cfg.left_trigger_threshold  <= 8'd30;
      cfg.right_trigger_threshold <= 8'd30;
      cfg.movement_threshold      <= 7'd40;
      cfg.cursor_deadzone         <= 7'd20;
      cfg.cursor_speed            <= 16'd256;
      cfg.cursor_curve            <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWAP:     cfg.swap_sticks             <= cfg_data[0];
        REG_RADIAL:   cfg.simple_radial           <= cfg_data[0];
        REG_LT_THR:   cfg.left_trigger_threshold  <= cfg_data[7:0];
        REG_RT_THR:   cfg.right_trigger_threshold <= cfg_data[7:0];
        REG_MOVE_THR: cfg.movement_threshold      <= cfg_data[6:0];
        REG_DEADZONE: cfg.cursor_deadzone         <= cfg_data[6:0];
        REG_SPEED:    cfg.cursor_speed            <= cfg_data;
        REG_CURVE:    cfg.cursor_curve            <= cfg_data;
        default:      ;
      endcase
    end
  end

  // front: classify items into target levels
  gkm_front u_front (
    .in_ch  (gp_in),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .ent    (f_ent)
  );

  // decoupling queue
  gkm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (f_ent),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head),
    .count     (q_count)
  );

  // back: pointer math and event sequencing
  gkm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (pop),
    .out_ch  (ev_out),
    .status  (status)
  );

  // queue never holds more than two items
  assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("queue count out of range");

  // a camera move is only shown while the camera is active
  assert property (@(posedge clk) disable iff (rst)
    ev_out.valid && ev_out.event_kind == KIND_MOVE |-> status.cam)
    else $error("camera move while camera inactive");

  // a release-all event leaves every kept level cleared
  assert property (@(posedge clk) disable iff (rst)
    ev_out.valid && ev_out.event_kind == KIND_RELEASE |->
      status.keys == '0 && status.mouse == 2'b00 && !status.cam)
    else $error("levels held after release all");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for gamepad_to_key_event_mapper_unit
// depends on gkm_pkg, gkm_if and the mapper rtl; predicts every event item
// from the items sent and checks them in order against ev_out

module testbench;
  import gkm_pkg::*;

  typedef struct {
    logic [1:0]        cmd;
    logic signed [7:0] lx, ly, rx, ry;
    logic [7:0]        lt, rt;
    logic [19:0]       btn;
    logic              allow;
  } pad_item_t;

  typedef struct {
    logic [2:0]         kind;
    logic [4:0]         code;
    logic               level;
    logic signed [31:0] mx, my;
    logic               last;
  } key_event_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 1000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  gkm_in_if  gp();
  gkm_out_if ev();

  gamepad_to_key_event_mapper_unit i_dut (
    .clk(clk), .rst(rst), .gp_in(gp), .ev_out(ev),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // mirrored configuration and kept levels
  cfg_t        cfg;
  logic [25:0] key_lv;
  logic [1:0]  mouse_lv;
  logic        cam_lv;

  key_event_t expected_events[$];
  int errors = 0;
  int items_sent = 0;
  int events_seen = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  int hold_req = 0;

  // ---------------- event prediction ----------------
  function automatic void add_event(logic [2:0] kind, logic [4:0] code, logic lvl,
                                    logic [31:0] mx, logic [31:0] my);
    key_event_t e;
    e.kind = kind; e.code = code; e.level = lvl; e.mx = mx; e.my = my; e.last = 0;
    expected_events.push_back(e);
  endfunction

  function automatic void drive_key(int code, bit down);
    if (key_lv[code] != down) begin
      key_lv[code] = down;
      add_event(KIND_KEY, 5'(code), down, 0, 0);
    end
  endfunction

  function automatic void drive_mouse(int code, bit down);
    if (mouse_lv[code] != down) begin
      mouse_lv[code] = down;
      add_event(KIND_MOUSE, 5'(code), down, 0, 0);
    end
  endfunction

  function automatic void drive_camera(bit on);
    if (cam_lv != on) begin
      cam_lv = on;
      add_event(KIND_CAM, '0, on, 0, 0);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // curved camera move of one pointer axis, q16 magnitude mq
  function automatic logic [31:0] curved_axis(int c, longint unsigned mq, longint unsigned dv);
    longint unsigned ac, num, a, s, t;
    logic [31:0] mag;
    ac  = (c < 0) ? -c : c;
    num = ac * (mq - (longint'(cfg.cursor_deadzone) << 16));
    a   = (num << 16) / (mq * dv);
    s   = (a * (longint'(cfg.cursor_speed) * longint'(cfg.cursor_curve))) / (64'd20 << 16);
    if (s >= (64'd1 << 32)) begin
      mag = 32'h7FFF_FFFF;
    end else begin
      t = (((s * s) >> 16) + s) >> SHIFT_DN;
      if (t > (64'h7FFF_FFFF >> SHIFT_UP)) mag = 32'h7FFF_FFFF;
      else mag = 32'(t << SHIFT_UP);
    end
    return (c < 0) ? -mag : mag;
  endfunction

  function automatic void predict_events(pad_item_t it);
    int n_before, mx, my, px, py, thr, ax, ay;
    bit lf, rg, up, dn, diag, active;
    longint unsigned m2, mq, dv;
    logic [31:0] ox, oy;
    n_before = expected_events.size();
    if (it.cmd == CMD_SNAP) begin
      mx = cfg.swap_sticks ? it.rx : it.lx;
      my = cfg.swap_sticks ? it.ry : it.ly;
      px = cfg.swap_sticks ? it.lx : it.rx;
      py = cfg.swap_sticks ? it.ly : it.ry;
      thr = cfg.movement_threshold;
      drive_key(0, it.lt > cfg.left_trigger_threshold);
      drive_key(1, it.rt > cfg.right_trigger_threshold);
      for (int i = 0; i < 18; i++) drive_key(2 + i, it.btn[i]);
      drive_mouse(0, it.allow && it.btn[18]);
      drive_mouse(1, it.allow && it.btn[19]);
      lf = mx < -thr; rg = mx > thr; up = my < -thr; dn = my > thr;
      ax = (mx < 0) ? -mx : mx;
      ay = (my < 0) ? -my : my;
      diag = (lf || rg) && (up || dn);
      drive_key(20, up);
      drive_key(21, lf);
      drive_key(22, dn);
      drive_key(23, rg);
      drive_key(24, !cfg.simple_radial && diag && 2 * ax > 3 * ay);
      drive_key(25, !cfg.simple_radial && diag && 2 * ay > 3 * ax);
      ox = 0; oy = 0;
      m2 = px * px + py * py;
      if (m2 != 0 && m2 >= longint'(cfg.cursor_deadzone) * cfg.cursor_deadzone) begin
        mq = int_sqrt(m2 << 32);
        // full deadzone would divide by zero, the unit uses one
        dv = (cfg.cursor_deadzone < 127) ? 127 - cfg.cursor_deadzone : 1;
        ox = curved_axis(px, mq, dv);
        oy = curved_axis(py, mq, dv);
      end
      active = it.allow && (ox != 0 || oy != 0);
      drive_camera(active);
      if (active) add_event(KIND_MOVE, '0, 0, ox, oy);
    end else if (it.cmd == CMD_CANCEL || it.cmd == CMD_RELEASE) begin
      drive_mouse(0, 0);
      drive_mouse(1, 0);
      drive_camera(0);
      if (it.cmd == CMD_RELEASE) begin
        for (int i = 0; i < NUM_KEYS; i++) drive_key(i, 0);
        add_event(KIND_RELEASE, '0, 0, 0, 0);
      end
    end
    // unused command: nothing changes
    if (expected_events.size() > n_before) expected_events[$].last = 1;
  endfunction

  // ---------------- event checker ----------------
  always @(posedge clk) begin
    key_event_t e;
    if (!rst && ev.valid && ev.ready) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("event item with nothing expected: kind %0d code %0d", ev.event_kind, ev.code);
        errors++;
      end else begin
        e = expected_events.pop_front();
        if (ev.event_kind !== e.kind) begin
          $error("event_kind exp %0d got %0d", e.kind, ev.event_kind); errors++;
        end
        if (ev.code !== e.code) begin
          $error("code exp %0d got %0d", e.code, ev.code); errors++;
        end
        if (ev.level !== e.level) begin
          $error("level exp %0d got %0d", e.level, ev.level); errors++;
        end
        if (ev.move_x !== e.mx) begin
          $error("move_x exp %0d got %0d", e.mx, ev.move_x); errors++;
        end
        if (ev.move_y !== e.my) begin
          $error("move_y exp %0d got %0d", e.my, ev.move_y); errors++;
        end
        if (ev.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, ev.last); errors++;
        end
      end
    end
  end

  // ---------------- event receiver with stalls ----------------
  int hold_cnt = 0;
  always @(posedge clk) begin
    int r;
    if (rst) begin
      ev.ready <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      r = $urandom_range(0, 199);
      if (hold_cnt > 0) begin
        hold_cnt--;
        ev.ready <= 1'b0;
      end else if (no_idle) begin
        ev.ready <= 1'b1;
      end else if (r == 0) begin
        // occasional long stall
        hold_cnt = $urandom_range(20, 120);
        ev.ready <= 1'b0;
      end else begin
        ev.ready <= (r >= 50);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (gp.valid && gp.ready) || (ev.valid && ev.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_item(pad_item_t it);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                        : $urandom_range(0, 2));
    if (gap > 0) begin
      gp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    gp.valid <= 1'b1;
    gp.cmd <= it.cmd;
    gp.left_x <= it.lx;  gp.left_y <= it.ly;
    gp.right_x <= it.rx; gp.right_y <= it.ry;
    gp.left_trigger <= it.lt; gp.right_trigger <= it.rt;
    gp.buttons <= it.btn;
    gp.allow_mouse <= it.allow;
    do @(posedge clk); while (!gp.ready);
    predict_events(it);
    items_sent++;
  endtask

  // waits until all events are out, then lets a slow snapshot finish
  task automatic wait_drained();
    gp.valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SWAP:     cfg.swap_sticks = val[0];
      REG_RADIAL:   cfg.simple_radial = val[0];
      REG_LT_THR:   cfg.left_trigger_threshold = val[7:0];
      REG_RT_THR:   cfg.right_trigger_threshold = val[7:0];
      REG_MOVE_THR: cfg.movement_threshold = val[6:0];
      REG_DEADZONE: cfg.cursor_deadzone = val[6:0];
      REG_SPEED:    cfg.cursor_speed = val;
      REG_CURVE:    cfg.cursor_curve = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int swp, int rad, int lt, int rt, int mv, int dz, int spd, int crv);
    wait_drained();
    write_reg(REG_SWAP, 16'(swp));
    write_reg(REG_RADIAL, 16'(rad));
    write_reg(REG_LT_THR, 16'(lt));
    write_reg(REG_RT_THR, 16'(rt));
    write_reg(REG_MOVE_THR, 16'(mv));
    write_reg(REG_DEADZONE, 16'(dz));
    write_reg(REG_SPEED, 16'(spd));
    write_reg(REG_CURVE, 16'(crv));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_axis();
    int r = $urandom_range(0, 9);
    case (r)
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'(cfg.movement_threshold + $urandom_range(0, 2) - 1);
      4: return 8'(-int'(cfg.movement_threshold) + $urandom_range(0, 2) - 1);
      5: return 8'(cfg.cursor_deadzone + $urandom_range(0, 2) - 1);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pad_item_t make_snap(logic [19:0] btn);
    pad_item_t it;
    it.cmd = CMD_SNAP;
    it.lx = pick_axis(); it.ly = pick_axis();
    it.rx = pick_axis(); it.ry = pick_axis();
    it.lt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
    it.rt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
    it.btn = btn;
    it.allow = ($urandom_range(0, 4) != 0);
    return it;
  endfunction

  function automatic pad_item_t make_cmd(logic [1:0] c);
    pad_item_t it = make_snap(20'($urandom));
    it.cmd = c;
    return it;
  endfunction

  // a held button set that flips a few bits per snapshot
  logic [19:0] held_btn = '0;

  task automatic send_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        for (int k = $urandom_range(0, 2); k > 0; k--) held_btn[$urandom_range(0, 19)] ^= 1'b1;
        send_item(make_snap(held_btn));
      end else if (r < 86) begin
        send_item(make_snap(20'($urandom)));
      end else if (r < 93) begin
        send_item(make_cmd(CMD_CANCEL));
      end else if (r < 98) begin
        send_item(make_cmd(CMD_RELEASE));
      end else begin
        send_item(make_cmd(2'd3));
      end
    end
  endtask

  function automatic pad_item_t snap_of(int lx, int ly, int rx, int ry, int lt, int rt,
                                        logic [19:0] btn, bit allow);
    pad_item_t it;
    it.cmd = CMD_SNAP;
    it.lx = 8'(lx); it.ly = 8'(ly); it.rx = 8'(rx); it.ry = 8'(ry);
    it.lt = 8'(lt); it.rt = 8'(rt); it.btn = btn; it.allow = allow;
    return it;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    send_item(snap_of(0, 0, 0, 0, 0, 0, '0, 1));               // nothing changes
    send_item(snap_of(127, 127, 127, 127, 255, 255, '1, 1));   // all buttons, triggers and mouse on
    send_item(snap_of(-128, -128, -128, -128, 255, 255, '1, 1));
    send_item(snap_of(120, -50, 20, 0, 31, 30, 20'h00001, 1));  // horizontal diagonal key
    send_item(snap_of(-50, 120, 19, 0, 30, 31, 20'h20000, 1));  // vertical diagonal key
    send_item(snap_of(90, 90, 0, 20, 0, 0, 20'hC0000, 0));      // deadzone edge, mouse blocked
    send_item(snap_of(0, 0, 14, 14, 0, 0, 20'hC0000, 1));       // inside deadzone
    send_item(make_cmd(CMD_CANCEL));
    send_item(snap_of(0, 0, 100, -100, 255, 0, 20'h40000, 1));
    send_item(make_cmd(CMD_RELEASE));
    send_item(make_cmd(2'd3));                                  // unused command
    send_item(snap_of(41, -41, -127, 127, 0, 255, 20'h3FFFF, 1));
    send_item(make_cmd(CMD_RELEASE));
    send_item(make_cmd(CMD_CANCEL));                            // nothing held
  endtask

  task automatic test_config_extremes();
    set_config(1, 1, 0, 255, 0, 0, 65535, 65535);
    send_item(snap_of(1, -1, 127, -128, 1, 255, '1, 1));
    send_item(snap_of(-128, 127, 0, 0, 0, 0, '0, 1));
    send_random(25);
    set_config(0, 0, 255, 0, 127, 127, 0, 1);
    send_item(snap_of(-128, -128, -128, 127, 255, 1, 20'h80000, 1));
    send_random(25);
    set_config(1, 0, 30, 30, 40, 126, 65535, 256);
    send_item(snap_of(-128, -128, 127, 0, 0, 0, '0, 1));
    send_random(25);
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 5; p++) begin
      set_config($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 2048), $urandom_range(0, 2048));
      no_idle = (p == 2);
      send_random(60);
      no_idle = 0;
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_req = 1500;
    no_idle = 1;
    for (int i = 0; i < 10; i++) send_item(make_snap(20'($urandom)));
    no_idle = 0;
  endtask

  initial begin
    gp.valid = 0; gp.cmd = '0;
    gp.left_x = 0; gp.left_y = 0; gp.right_x = 0; gp.right_y = 0;
    gp.left_trigger = 0; gp.right_trigger = 0; gp.buttons = '0; gp.allow_mouse = 0;
    cfg = '{swap_sticks: 0, simple_radial: 0, left_trigger_threshold: 30,
            right_trigger_threshold: 30, movement_threshold: 40, cursor_deadzone: 20,
            cursor_speed: 256, cursor_curve: 256};
    key_lv = '0; mouse_lv = '0; cam_lv = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random_configs();
    test_backpressure();
    set_config(0, 0, 30, 30, 40, 20, 256, 256);
    send_random(20);
    wait_drained();

    $display("covered %0d input items and %0d event items over several register settings",
             items_sent, events_seen);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- gamepad_to_key_event_mapper_unit.f -----
rtl/gkm_pkg.sv
rtl/gkm_if.sv
rtl/gkm_front.sv
rtl/gkm_queue.sv
rtl/gkm_back.sv
rtl/gamepad_to_key_event_mapper_unit.sv
bench/testbench.sv
